// ===== hw/rtl/sbc_pkg.sv =====
// Shared types, queue sizes and the round constant table of the SHA-256 block engine.
package sbc_pkg;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;
   localparam int ROUNDS          = 64;
   localparam int MSG_WORDS       = 16;
   localparam int CHAIN_WORDS     = 8;

   typedef enum logic [1:0] {
      OP_CHAIN,
      OP_MSG,
      OP_START
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  word_index;
      logic [31:0] word_value;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  digest_index;
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ===== hw/rtl/sbc_fifo.sv =====
// Small synchronous first-in first-out queue built from flip-flops.
module sbc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sbc_front.sv =====
// Input side: takes words from the requester, sorts them and drops chaining words out of range.
module sbc_front
   import sbc_pkg::*;
(
   input  logic        req_push,
   input  logic        req_cmd,
   input  logic [3:0]  req_word_index,
   input  logic [31:0] req_word_value,
   output logic        req_full,
   output logic        q_push,
   output cmd_type     q_data,
   input  logic        q_full
);

   logic accept;
   logic ignored;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   // Chaining words only exist at positions 0 to 7; anything above is dropped here.
   assign ignored  = !req_cmd && req_word_index[3];
   assign q_push   = accept && !ignored;

   always_comb begin
      q_data.word_index = req_word_index;
      q_data.word_value = req_word_value;
      if (!req_cmd) begin
         q_data.op = OP_CHAIN;
      end else if (req_word_index == 4'(MSG_WORDS - 1)) begin
         q_data.op = OP_START;
      end else begin
         q_data.op = OP_MSG;
      end
   end

endmodule

// ===== hw/rtl/sbc_core.sv =====
// Back end: word stores, message schedule window, one compression round per cycle and digest output.
module sbc_core
   import sbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd_data,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   state_type   state_ff, state_in;
   logic [31:0] chain_ff  [CHAIN_WORDS];
   logic [31:0] chain_in  [CHAIN_WORDS];
   logic [31:0] msg_ff    [MSG_WORDS];
   logic [31:0] msg_in    [MSG_WORDS];
   logic [31:0] win_ff    [MSG_WORDS];
   logic [31:0] win_in    [MSG_WORDS];
   logic [31:0] vars_ff   [CHAIN_WORDS];
   logic [31:0] vars_in   [CHAIN_WORDS];
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic [31:0] big0, big1, choose, major, p_sum, q_sum;
   logic [31:0] sig0, sig1, next_w;

   // Round datapath; the schedule window holds w[i] at position 0.
   always_comb begin
      big1   = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
      choose = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      big0   = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
      major  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]);
      p_sum  = vars_ff[7] + big1 + choose + round_k(round_ff) + win_ff[0];
      q_sum  = big0 + major;
      sig0   = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      sig1   = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      next_w = sig1 + win_ff[9] + sig0 + win_ff[0];
   end

   always_comb begin
      state_in   = state_ff;
      chain_in   = chain_ff;
      msg_in     = msg_ff;
      win_in     = win_ff;
      vars_in    = vars_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_data.digest_index = out_idx_ff;
      rsp_data.digest_word  = vars_ff[0];
      rsp_data.last_word    = (out_idx_ff == 3'(CHAIN_WORDS - 1));

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_CHAIN: begin
                     chain_in[cmd_data.word_index[2:0]] = cmd_data.word_value;
                  end
                  OP_MSG: begin
                     msg_in[cmd_data.word_index] = cmd_data.word_value;
                  end
                  OP_START: begin
                     msg_in[cmd_data.word_index] = cmd_data.word_value;
                     state_in = ST_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            win_in   = msg_ff;
            vars_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            for (int j = 0; j < MSG_WORDS - 1; j++) begin
               win_in[j] = win_ff[j+1];
            end
            win_in[MSG_WORDS-1] = next_w;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + p_sum;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = p_sum + q_sum;
            round_in   = round_ff + 1'b1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int j = 0; j < CHAIN_WORDS; j++) begin
               vars_in[j] = chain_ff[j] + vars_ff[j];
            end
            out_idx_in = '0;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // Digest words leave from position 0 while the rest move down.
            if (!rsp_full) begin
               rsp_push = 1'b1;
               for (int j = 0; j < CHAIN_WORDS - 1; j++) begin
                  vars_in[j] = vars_ff[j+1];
               end
               out_idx_in = out_idx_ff + 1'b1;
               if (out_idx_ff == 3'(CHAIN_WORDS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         round_ff   <= '0;
         out_idx_ff <= '0;
         for (int j = 0; j < CHAIN_WORDS; j++) begin
            chain_ff[j] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         chain_ff   <= chain_in;
      end
      msg_ff  <= msg_in;
      win_ff  <= win_in;
      vars_ff <= vars_in;
   end

endmodule

// ===== hw/rtl/sha256_block_compress.sv =====
// Top level of the SHA-256 block compression engine: front end, command queue, core, result queue.
//
//   channel   direction  handshake          word
//   req_      in         req_push/req_full  cmd, word_index, word_value
//   rsp_      out        rsp_pop/rsp_empty  digest_index, digest_word, last_word
//
// The core takes loaded words from the command queue only while idle.
// Message word 15 starts a run: a copy step, 64 rounds (one round per cycle in
// the core), a feed-forward step, then eight digest words at one per cycle while
// the result queue has room. Words keep arriving into the command queue during
// a run. Reset clears the chaining words and all control.
module sha256_block_compress
   import sbc_pkg::*;
#(
   parameter int CmdDepth = CMD_QUEUE_DEPTH,
   parameter int RspDepth = RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [3:0]  req_word_index,
   input  logic [31:0] req_word_value,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [2:0]  rsp_digest_index,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);

   logic    cmd_q_push, cmd_q_full, cmd_q_pop, cmd_q_empty;
   cmd_type cmd_q_in, cmd_q_out;
   logic    rsp_q_push, rsp_q_full;
   rsp_type rsp_q_in, rsp_q_out;

   sbc_front u_front (
      .req_push       (req_push),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .req_full       (req_full),
      .q_push         (cmd_q_push),
      .q_data         (cmd_q_in),
      .q_full         (cmd_q_full)
   );

   sbc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CmdDepth)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_q_push),
      .push_data (cmd_q_in),
      .full      (cmd_q_full),
      .pop       (cmd_q_pop),
      .pop_data  (cmd_q_out),
      .empty     (cmd_q_empty)
   );

   sbc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_q_out),
      .cmd_empty (cmd_q_empty),
      .cmd_pop   (cmd_q_pop),
      .rsp_push  (rsp_q_push),
      .rsp_data  (rsp_q_in),
      .rsp_full  (rsp_q_full)
   );

   sbc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RspDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_q_push),
      .push_data (rsp_q_in),
      .full      (rsp_q_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_out),
      .empty     (rsp_empty)
   );

   assign rsp_digest_index = rsp_q_out.digest_index;
   assign rsp_digest_word  = rsp_q_out.digest_word;
   assign rsp_last_word    = rsp_q_out.last_word;

`ifndef SYNTHESIS
   a_cmd_push_from_req: assert property (@(posedge clock) disable iff (reset)
      cmd_q_push |-> (req_push && !req_full))
      else $error("command queue written without an accepted word");

   a_rsp_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_q_push |-> !rsp_q_full)
      else $error("result queue written while full");

   a_last_is_seventh: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_word) |-> (rsp_digest_index == 3'(CHAIN_WORDS - 1)))
      else $error("last digest word marked at wrong index");

   a_no_pop_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_q_push |-> !cmd_q_pop)
      else $error("core took a command while emitting digest words");
`endif

endmodule
